// ===== sv/spread_weighted_palette_sampler_macros.svh =====
// assertion helpers for the palette sampler
`ifndef SPREAD_WEIGHTED_PALETTE_SAMPLER_MACROS_SVH
`define SPREAD_WEIGHTED_PALETTE_SAMPLER_MACROS_SVH

// same-cycle implication
`define SPWPS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("palette sampler check failed");

// next-cycle implication
`define SPWPS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("palette sampler check failed");

`endif

// ===== sv/spwps_pkg.sv =====
`default_nettype none
package spwps_pkg;

    localparam int ENTRIES     = 16;
    localparam int TABLE_DEPTH = 256;

    localparam int IDX_W  = $clog2(ENTRIES);
    localparam int CNT_W  = $clog2(ENTRIES + 1);
    localparam int TD_W   = $clog2(TABLE_DEPTH + 1);
    localparam int SUM_W  = 17 + IDX_W;
    localparam int ACC_W  = SUM_W + 8;
    localparam int DVD_W  = (ACC_W + 1 > 33) ? ACC_W + 1 : 33;
    localparam int DVS_W  = (SUM_W + 1 > 17) ? SUM_W + 1 : 17;
    localparam int QUO_W  = 20;
    localparam int STEP_W = 5;
    localparam int MUL_W  = 20;

    localparam logic [STEP_W-1:0] X_STEPS  = 5'd17;
    localparam logic [STEP_W-1:0] R_STEPS  = 5'd20;
    localparam logic [STEP_W-1:0] CH_STEPS = 5'd8;

    localparam logic [16:0] ONE_Q16  = 17'h10000;
    localparam logic [16:0] HALF_Q16 = 17'h08000;
    localparam logic [31:0] BLACK    = 32'hFF00_0000;

    localparam logic [1:0] OP_SAMPLE = 2'd0;
    localparam logic [1:0] OP_WRITE  = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    localparam logic [1:0] ST_DONE = 2'd0;
    localparam logic [1:0] ST_OVER = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    localparam logic [1:0] MODE_LINEAR = 2'd0;
    localparam logic [1:0] MODE_QUAD   = 2'd1;
    localparam logic [1:0] MODE_GAUSS  = 2'd2;
    localparam logic [1:0] MODE_COS    = 2'd3;

    localparam logic [1:0] CFG_MODE  = 2'd0;
    localparam logic [1:0] CFG_WRAP  = 2'd1;
    localparam logic [1:0] CFG_SIGMA = 2'd2;

    localparam logic [16:0] SIGMA_RESET = 17'd22938;

    localparam longint unsigned ONE_Q30     = 64'd1073741824;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    typedef logic [16:0] tab_t [0:TABLE_DEPTH];

    // shift-subtract division, only used while building the tables
    function automatic longint unsigned div_u64(longint unsigned num, longint unsigned den);
        longint unsigned quo;
        longint unsigned rem;
        quo = 0;
        rem = 0;
        for (int b = 63; b >= 0; b--)
        begin
            rem = {rem[62:0], num[b]};
            quo = quo << 1;
            if (rem >= den)
            begin
                rem = rem - den;
                quo = quo | 64'd1;
            end
        end
        return quo;
    endfunction

    // exp(-f), f and result in q30, series evaluated at elaboration
    function automatic longint unsigned exp_neg_q30(longint unsigned f);
        longint sum;
        longint unsigned term;
        sum  = longint'(ONE_Q30);
        term = ONE_Q30;
        for (int k = 1; k <= 20; k++)
        begin
            term = div_u64((term * f) >> 30, longint'(k));
            if (k % 2 == 1)
                sum = sum - longint'(term);
            else
                sum = sum + longint'(term);
        end
        if (sum < 0)
            sum = 0;
        return longint'(sum);
    endfunction

    function automatic longint unsigned cos_q30(longint unsigned t);
        longint unsigned t2;
        longint sum;
        longint unsigned term;
        t2   = (t * t) >> 30;
        sum  = longint'(ONE_Q30);
        term = ONE_Q30;
        for (int k = 1; k <= 10; k++)
        begin
            term = div_u64((term * t2) >> 30, longint'((2 * k - 1) * (2 * k)));
            if (k % 2 == 1)
                sum = sum - longint'(term);
            else
                sum = sum + longint'(term);
        end
        if (sum < 0)
            sum = 0;
        if (sum > longint'(ONE_Q30))
            sum = longint'(ONE_Q30);
        return longint'(sum);
    endfunction

    function automatic tab_t build_exp();
        tab_t tab;
        longint unsigned e1;
        longint unsigned a;
        longint unsigned n;
        longint unsigned v;
        e1 = exp_neg_q30(ONE_Q30);
        for (int i = 0; i <= TABLE_DEPTH; i++)
        begin
            a = (longint'(i) << 34) / TABLE_DEPTH;
            n = a >> 30;
            v = exp_neg_q30(a & (ONE_Q30 - 1));
            while (n > 0)
            begin
                v = (v * e1) >> 30;
                n = n - 1;
            end
            tab[i] = 17'((v + 8192) >> 14);
        end
        return tab;
    endfunction

    function automatic tab_t build_cos();
        tab_t tab;
        longint unsigned c;
        for (int i = 0; i <= TABLE_DEPTH; i++)
        begin
            c = cos_q30((HALF_PI_Q30 * longint'(i)) / TABLE_DEPTH);
            c = (c * c) >> 30;
            tab[i] = 17'((c + 8192) >> 14);
        end
        return tab;
    endfunction

    localparam tab_t EXP_TAB = build_exp();
    localparam tab_t COS_TAB = build_cos();

endpackage
`default_nettype wire

// ===== sv/spwps_div.sv =====
`default_nettype none
module spwps_div
    import spwps_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [DVD_W-1:0]  dividend,
    input  wire logic [DVS_W-1:0]  divisor,
    input  wire logic [STEP_W-1:0] steps,
    output logic                   done,
    output logic [QUO_W-1:0]       quotient
);

    localparam int SH_W = $clog2(DVD_W + 1);

    logic [DVS_W-1:0]  rem_reg, rem_next;
    logic [DVD_W-1:0]  dvd_reg, dvd_next;
    logic [DVS_W-1:0]  dvs_reg, dvs_next;
    logic [QUO_W-1:0]  quo_reg, quo_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic              run_reg, run_next;
    logic              done_reg, done_next;
    logic [DVS_W:0]    trial;
    logic [SH_W-1:0]   shamt;

    assign shamt = SH_W'(DVD_W) - SH_W'(steps);
    assign trial = {rem_reg, dvd_reg[DVD_W-1]};

    always_comb
    begin
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start)
        begin
            // top bits are known to be below the divisor
            rem_next = DVS_W'(dividend >> steps);
            dvd_next = dividend << shamt;
            dvs_next = divisor;
            quo_next = '0;
            cnt_next = steps;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = DVS_W'(trial - {1'b0, dvs_reg});
                quo_next = {quo_reg[QUO_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DVS_W-1:0];
                quo_next = {quo_reg[QUO_W-2:0], 1'b0};
            end
            dvd_next = dvd_reg << 1;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == STEP_W'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule
`default_nettype wire

// ===== sv/spread_weighted_palette_sampler.sv =====
`default_nettype none
// palette sampler: a table of up to ENTRIES colour stops (position, spread, rgba)
// and a weighted-mean sampler over them.
// requests: operation and its fields are taken when start is high and busy is
// low. sample reads sample_point, write takes position, spread and colour,
// clear empties the table. every request gives one result: red, green, blue,
// alpha and status, shown for exactly one cycle while done is high.
// configuration: cfg_valid with cfg_index and cfg_data, cfg_ready is always
// high; write registers only while busy is low.
// a write scans the stops one per cycle; clear answers in the cycle after the
// request. a sample visits the stops in order, weighting each stop in reach,
// then runs the four channel divisions; stops out of reach are skipped.
// one bit-serial divider and one 20x20 multiplier are shared by the steps that use them.
// one request at a time: busy stays high until the result cycle ends.
// reset clears the table count and the registers to their defaults.
// results cannot be held off by the receiver.
`include "spread_weighted_palette_sampler_macros.svh"
module spread_weighted_palette_sampler
    import spwps_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  operation,
    input  wire logic [16:0] position,
    input  wire logic [15:0] sample_point,
    input  wire logic [31:0] colour,
    input  wire logic [16:0] spread,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [16:0] cfg_data,
    output logic             done,
    output logic [7:0]       red,
    output logic [7:0]       green,
    output logic [7:0]       blue,
    output logic [7:0]       alpha,
    output logic [1:0]       status
);

    localparam int PW = 17 + TD_W + 1;

    typedef enum logic [17:0] {
        S_IDLE  = 18'h00001,
        S_SCAN  = 18'h00002,
        S_DIST  = 18'h00004,
        S_XDIV  = 18'h00008,
        S_WSEL  = 18'h00010,
        S_QUAD  = 18'h00020,
        S_RDIV  = 18'h00040,
        S_RSQ   = 18'h00080,
        S_GEXP  = 18'h00100,
        S_TRD   = 18'h00200,
        S_TMUL  = 18'h00400,
        S_TFIN  = 18'h00800,
        S_AMUL  = 18'h01000,
        S_AADD  = 18'h02000,
        S_NEXT  = 18'h04000,
        S_FDIV  = 18'h08000,
        S_FWAIT = 18'h10000,
        S_OUT   = 18'h20000
    } state_t;

    state_t state_reg, state_next;

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [1:0]       mode_reg, mode_next;
    logic             wrap_reg, wrap_next;
    logic [16:0]      sigma_reg, sigma_next;

    logic [1:0]       op_reg, op_next;
    logic [16:0]      pin_reg, pin_next;
    logic [15:0]      pt_reg, pt_next;
    logic [31:0]      cin_reg, cin_next;
    logic [16:0]      sin_reg, sin_next;
    logic [1:0]       ch_reg, ch_next;
    logic [16:0]      x_reg, x_next;
    logic [19:0]      r_reg, r_next;
    logic [16:0]      u_reg, u_next;
    logic [16:0]      ta_reg, ta_next;
    logic [16:0]      tb_reg, tb_next;
    logic [15:0]      f_reg, f_next;
    logic [16:0]      w_reg, w_next;
    logic [ACC_W-1:0] acc_reg [4];
    logic [ACC_W-1:0] acc_next [4];
    logic [SUM_W-1:0] sum_reg, sum_next;
    logic [31:0]      rgba_reg, rgba_next;
    logic [1:0]       status_reg, status_next;
    logic [2*MUL_W-1:0] mul_reg;

    logic [16:0] pos_mem_reg [0:ENTRIES-1];
    logic [16:0] spr_mem_reg [0:ENTRIES-1];
    logic [31:0] col_mem_reg [0:ENTRIES-1];

    logic             mem_we;
    logic             mem_pos_we;
    logic [IDX_W-1:0] mem_waddr;

    logic [MUL_W-1:0]  mul_a, mul_b;
    logic              div_start;
    logic [DVD_W-1:0]  div_dvd;
    logic [DVS_W-1:0]  div_dvs;
    logic [STEP_W-1:0] div_steps;
    logic              div_done;
    logic [QUO_W-1:0]  div_q;

    logic [IDX_W-1:0] idx_i;
    logic [16:0]      stop_pos, stop_spr;
    logic [31:0]      stop_col;
    logic [16:0]      pt17, dist_raw, dist_fold;
    logic [16:0]      sig_eff;
    logic [PW-1:0]    tab_p;
    logic [PW-17:0]   tab_i;
    logic [16:0]      tdiff, tadj;
    logic [2*MUL_W-18:0] sq_half;

    spwps_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .steps    (div_steps),
        .done     (div_done),
        .quotient (div_q)
    );

    assign idx_i     = idx_reg[IDX_W-1:0];
    assign stop_pos  = pos_mem_reg[idx_i];
    assign stop_spr  = spr_mem_reg[idx_i];
    assign stop_col  = col_mem_reg[idx_i];
    assign pt17      = {1'b0, pt_reg};
    assign dist_raw  = (pt17 > stop_pos) ? pt17 - stop_pos : stop_pos - pt17;
    assign dist_fold = (wrap_reg && dist_raw > HALF_Q16) ? ONE_Q16 - dist_raw : dist_raw;
    assign sig_eff   = (sigma_reg == '0) ? 17'd1 : sigma_reg;
    assign tab_p     = PW'(u_reg) * PW'(TABLE_DEPTH);
    assign tab_i     = tab_p[PW-1:16];
    assign tdiff     = (ta_reg >= tb_reg) ? ta_reg - tb_reg : tb_reg - ta_reg;
    assign tadj      = 17'((mul_reg + (2*MUL_W)'(32768)) >> 16);
    assign sq_half   = mul_reg[2*MUL_W-1:17];

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        idx_next    = idx_reg;
        mode_next   = mode_reg;
        wrap_next   = wrap_reg;
        sigma_next  = sigma_reg;
        op_next     = op_reg;
        pin_next    = pin_reg;
        pt_next     = pt_reg;
        cin_next    = cin_reg;
        sin_next    = sin_reg;
        ch_next     = ch_reg;
        x_next      = x_reg;
        r_next      = r_reg;
        u_next      = u_reg;
        ta_next     = ta_reg;
        tb_next     = tb_reg;
        f_next      = f_reg;
        w_next      = w_reg;
        acc_next    = acc_reg;
        sum_next    = sum_reg;
        rgba_next   = rgba_reg;
        status_next = status_reg;
        mem_we      = 1'b0;
        mem_pos_we  = 1'b0;
        mem_waddr   = idx_i;
        mul_a       = '0;
        mul_b       = '0;
        div_start   = 1'b0;
        div_dvd     = '0;
        div_dvs     = '0;
        div_steps   = X_STEPS;

        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_MODE:  mode_next  = cfg_data[1:0];
                CFG_WRAP:  wrap_next  = cfg_data[0];
                CFG_SIGMA: sigma_next = cfg_data;
                default:   ;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next     = operation;
                    pin_next    = (position > ONE_Q16) ? ONE_Q16 : position;
                    sin_next    = (spread > ONE_Q16) ? ONE_Q16 : spread;
                    pt_next     = sample_point;
                    cin_next    = colour;
                    rgba_next   = '0;
                    status_next = ST_DONE;
                    idx_next    = '0;
                    unique case (operation)
                        OP_SAMPLE:
                        begin
                            if (cnt_reg == '0)
                            begin
                                rgba_next  = BLACK;
                                state_next = S_OUT;
                            end
                            else if (cnt_reg == CNT_W'(1))
                            begin
                                rgba_next  = col_mem_reg[0];
                                state_next = S_OUT;
                            end
                            else
                            begin
                                sum_next   = '0;
                                for (int c = 0; c < 4; c++)
                                    acc_next[c] = '0;
                                state_next = S_DIST;
                            end
                        end
                        OP_WRITE:
                            state_next = S_SCAN;
                        OP_CLEAR:
                        begin
                            cnt_next   = '0;
                            state_next = S_OUT;
                        end
                        default:
                            state_next = S_OUT;
                    endcase
                end
            end

            S_SCAN:
            begin
                if (idx_reg == cnt_reg)
                begin
                    if (cnt_reg < CNT_W'(ENTRIES))
                    begin
                        mem_we     = 1'b1;
                        mem_pos_we = 1'b1;
                        cnt_next   = cnt_reg + 1'b1;
                    end
                    else
                        status_next = ST_FULL;
                    state_next = S_OUT;
                end
                else if (stop_pos == pin_reg)
                begin
                    mem_we      = 1'b1;
                    status_next = ST_OVER;
                    state_next  = S_OUT;
                end
                else
                    idx_next = idx_reg + 1'b1;
            end

            S_DIST:
            begin
                if (stop_spr == '0)
                begin
                    // zero-spread stop only counts on an exact hit
                    if (dist_fold == '0)
                    begin
                        rgba_next  = stop_col;
                        state_next = S_OUT;
                    end
                    else
                        state_next = S_NEXT;
                end
                else if (dist_fold > stop_spr)
                    state_next = S_NEXT;
                else
                begin
                    div_start  = 1'b1;
                    div_dvd    = DVD_W'({dist_fold, 16'h0000});
                    div_dvs    = DVS_W'(stop_spr);
                    div_steps  = X_STEPS;
                    state_next = S_XDIV;
                end
            end

            S_XDIV:
            begin
                if (div_done)
                begin
                    x_next     = (div_q > QUO_W'(ONE_Q16)) ? ONE_Q16 : div_q[16:0];
                    state_next = S_WSEL;
                end
            end

            S_WSEL:
            begin
                unique case (mode_reg)
                    MODE_LINEAR:
                    begin
                        w_next     = ONE_Q16 - x_reg;
                        ch_next    = '0;
                        state_next = S_AMUL;
                    end
                    MODE_QUAD:
                    begin
                        mul_a      = MUL_W'(ONE_Q16 - x_reg);
                        mul_b      = MUL_W'(ONE_Q16 - x_reg);
                        state_next = S_QUAD;
                    end
                    MODE_GAUSS:
                    begin
                        // quotient at or above 2^20 saturates anyway
                        if ({4'b0000, x_reg} >= {sig_eff, 4'b0000})
                        begin
                            r_next     = 20'h80000;
                            state_next = S_RSQ;
                        end
                        else
                        begin
                            div_start  = 1'b1;
                            div_dvd    = DVD_W'({x_reg, 16'h0000});
                            div_dvs    = DVS_W'(sig_eff);
                            div_steps  = R_STEPS;
                            state_next = S_RDIV;
                        end
                    end
                    default:
                    begin
                        u_next     = x_reg;
                        state_next = S_TRD;
                    end
                endcase
            end

            S_QUAD:
            begin
                w_next     = tadj;
                ch_next    = '0;
                state_next = S_AMUL;
            end

            S_RDIV:
            begin
                if (div_done)
                begin
                    r_next     = (div_q > 20'h80000) ? 20'h80000 : div_q;
                    state_next = S_RSQ;
                end
            end

            S_RSQ:
            begin
                mul_a      = r_reg;
                mul_b      = r_reg;
                state_next = S_GEXP;
            end

            S_GEXP:
            begin
                u_next     = (sq_half > (2*MUL_W-17)'(21'h100000)) ? ONE_Q16
                                                                   : 17'(sq_half >> 4);
                state_next = S_TRD;
            end

            S_TRD:
            begin
                if (tab_i >= (PW-16)'(TABLE_DEPTH))
                begin
                    ta_next = (mode_reg == MODE_GAUSS) ? EXP_TAB[TABLE_DEPTH]
                                                       : COS_TAB[TABLE_DEPTH];
                    tb_next = ta_next;
                    f_next  = '0;
                end
                else
                begin
                    ta_next = (mode_reg == MODE_GAUSS) ? EXP_TAB[TD_W'(tab_i)]
                                                       : COS_TAB[TD_W'(tab_i)];
                    tb_next = (mode_reg == MODE_GAUSS) ? EXP_TAB[TD_W'(tab_i + 1'b1)]
                                                       : COS_TAB[TD_W'(tab_i + 1'b1)];
                    f_next  = tab_p[15:0];
                end
                state_next = S_TMUL;
            end

            S_TMUL:
            begin
                mul_a      = MUL_W'(tdiff);
                mul_b      = MUL_W'(f_reg);
                state_next = S_TFIN;
            end

            S_TFIN:
            begin
                w_next     = (tb_reg <= ta_reg) ? ta_reg - tadj : ta_reg + tadj;
                ch_next    = '0;
                state_next = S_AMUL;
            end

            S_AMUL:
            begin
                mul_a      = MUL_W'(w_reg);
                mul_b      = MUL_W'(stop_col[8*ch_reg +: 8]);
                state_next = S_AADD;
            end

            S_AADD:
            begin
                acc_next[ch_reg] = acc_reg[ch_reg] + ACC_W'(mul_reg);
                if (ch_reg == 2'd3)
                begin
                    sum_next   = sum_reg + SUM_W'(w_reg);
                    state_next = S_NEXT;
                end
                else
                begin
                    ch_next    = ch_reg + 1'b1;
                    state_next = S_AMUL;
                end
            end

            S_NEXT:
            begin
                if (idx_reg + 1'b1 >= cnt_reg)
                begin
                    if (sum_reg == '0)
                    begin
                        rgba_next  = BLACK;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        ch_next    = '0;
                        state_next = S_FDIV;
                    end
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_DIST;
                end
            end

            S_FDIV:
            begin
                // rounded mean: (2 acc + sum) / (2 sum)
                div_start  = 1'b1;
                div_dvd    = DVD_W'({acc_reg[ch_reg], 1'b0}) + DVD_W'(sum_reg);
                div_dvs    = DVS_W'({sum_reg, 1'b0});
                div_steps  = CH_STEPS;
                state_next = S_FWAIT;
            end

            S_FWAIT:
            begin
                if (div_done)
                begin
                    rgba_next[8*ch_reg +: 8] = div_q[7:0];
                    if (ch_reg == 2'd3)
                        state_next = S_OUT;
                    else
                    begin
                        ch_next    = ch_reg + 1'b1;
                        state_next = S_FDIV;
                    end
                end
            end

            S_OUT:
                state_next = S_IDLE;

            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            idx_reg   <= '0;
            ch_reg    <= '0;
            mode_reg  <= MODE_LINEAR;
            wrap_reg  <= 1'b0;
            sigma_reg <= SIGMA_RESET;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            idx_reg   <= idx_next;
            ch_reg    <= ch_next;
            mode_reg  <= mode_next;
            wrap_reg  <= wrap_next;
            sigma_reg <= sigma_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        pin_reg    <= pin_next;
        pt_reg     <= pt_next;
        cin_reg    <= cin_next;
        sin_reg    <= sin_next;
        x_reg      <= x_next;
        r_reg      <= r_next;
        u_reg      <= u_next;
        ta_reg     <= ta_next;
        tb_reg     <= tb_next;
        f_reg      <= f_next;
        w_reg      <= w_next;
        acc_reg    <= acc_next;
        sum_reg    <= sum_next;
        rgba_reg   <= rgba_next;
        status_reg <= status_next;
        mul_reg    <= mul_a * mul_b;
        if (mem_we)
        begin
            spr_mem_reg[mem_waddr] <= sin_reg;
            col_mem_reg[mem_waddr] <= cin_reg;
            if (mem_pos_we)
                pos_mem_reg[mem_waddr] <= pin_reg;
        end
    end

    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign done      = (state_reg == S_OUT);
    assign red       = rgba_reg[7:0];
    assign green     = rgba_reg[15:8];
    assign blue      = rgba_reg[23:16];
    assign alpha     = rgba_reg[31:24];
    assign status    = status_reg;

    `SPWPS_ASSERT_NOW(a_state_onehot, 1'b1, $onehot(state_reg))
    `SPWPS_ASSERT_NEXT(a_done_single, done, !done && !busy)
    `SPWPS_ASSERT_NEXT(a_start_busy, start && !busy, busy)
    `SPWPS_ASSERT_NOW(a_full_count, done && status == ST_FULL && op_reg == OP_WRITE,
                      cnt_reg == CNT_W'(ENTRIES))

endmodule
`default_nettype wire

// ===== sim/spread_weighted_palette_sampler_tb.sv =====
`timescale 1ns / 1ps
module spread_weighted_palette_sampler_tb;
    import spwps_pkg::*;

    localparam int CYCLE_LIMIT = 8000000;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic [1:0] status;
    } pixel_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  operation;
    logic [16:0] position;
    logic [15:0] sample_point;
    logic [31:0] colour;
    logic [16:0] spread;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [16:0] cfg_data;
    logic        done;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [1:0]  status;

    spread_weighted_palette_sampler dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .operation(operation), .position(position), .sample_point(sample_point),
        .colour(colour), .spread(spread), .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .done(done), .red(red), .green(green), .blue(blue), .alpha(alpha),
        .status(status)
    );

    // predictor state
    logic [16:0] stop_pos [0:ENTRIES-1];
    logic [16:0] stop_spr [0:ENTRIES-1];
    logic [31:0] stop_rgba [0:ENTRIES-1];
    int          stop_count;
    logic [1:0]  falloff;
    logic        wrap_on;
    logic [16:0] sigma;
    longint unsigned exp_rom [0:TABLE_DEPTH];
    longint unsigned cos_rom [0:TABLE_DEPTH];

    pixel_t pending_pixels [$];
    int     mismatches;
    int     idle_pct;
    longint cycles;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic longint unsigned exp_series(longint unsigned f);
        longint acc;
        longint unsigned term;
        acc  = longint'(ONE_Q30);
        term = ONE_Q30;
        for (longint unsigned k = 1; k <= 20; k++)
        begin
            term = ((term * f) >> 30) / k;
            if (k[0])
                acc = acc - longint'(term);
            else
                acc = acc + longint'(term);
        end
        return (acc < 0) ? 0 : longint'(acc);
    endfunction

    function automatic longint unsigned cos_series(longint unsigned t);
        longint unsigned t2;
        longint acc;
        longint unsigned term;
        t2   = (t * t) >> 30;
        acc  = longint'(ONE_Q30);
        term = ONE_Q30;
        for (longint unsigned k = 1; k <= 10; k++)
        begin
            term = ((term * t2) >> 30) / ((2 * k - 1) * (2 * k));
            if (k[0])
                acc = acc - longint'(term);
            else
                acc = acc + longint'(term);
        end
        if (acc < 0)
            acc = 0;
        if (acc > longint'(ONE_Q30))
            acc = longint'(ONE_Q30);
        return longint'(acc);
    endfunction

    task automatic fill_roms();
        longint unsigned e1;
        longint unsigned a;
        longint unsigned n;
        longint unsigned v;
        longint unsigned c;
        e1 = exp_series(ONE_Q30);
        for (int i = 0; i <= TABLE_DEPTH; i++)
        begin
            a = (longint'(i) << 34) / TABLE_DEPTH;
            n = a >> 30;
            v = exp_series(a & (ONE_Q30 - 1));
            while (n > 0)
            begin
                v = (v * e1) >> 30;
                n = n - 1;
            end
            exp_rom[i] = (v + 8192) >> 14;
            c = cos_series((HALF_PI_Q30 * longint'(i)) / TABLE_DEPTH);
            c = (c * c) >> 30;
            cos_rom[i] = (c + 8192) >> 14;
        end
    endtask

    function automatic longint unsigned interp(bit use_cos, longint unsigned u);
        longint unsigned p;
        longint unsigned i;
        longint unsigned f;
        longint unsigned lo;
        longint unsigned hi;
        p = u * TABLE_DEPTH;
        i = p >> 16;
        f = p & 64'hFFFF;
        if (i >= TABLE_DEPTH)
            return use_cos ? cos_rom[TABLE_DEPTH] : exp_rom[TABLE_DEPTH];
        lo = use_cos ? cos_rom[i] : exp_rom[i];
        hi = use_cos ? cos_rom[i+1] : exp_rom[i+1];
        if (hi <= lo)
            return lo - (((lo - hi) * f + 32768) >> 16);
        return lo + (((hi - lo) * f + 32768) >> 16);
    endfunction

    function automatic longint unsigned falloff_weight(longint unsigned gap,
                                                       longint unsigned spr);
        longint unsigned x;
        longint unsigned s;
        longint unsigned r;
        longint unsigned a;
        x = (gap << 16) / spr;
        if (x > 65536)
            x = 65536;
        case (falloff)
            MODE_LINEAR: return 65536 - x;
            MODE_QUAD:   return ((65536 - x) * (65536 - x) + 32768) >> 16;
            MODE_GAUSS:
            begin
                s = (sigma == 0) ? 1 : sigma;
                r = (x << 16) / s;
                if (r > (1 << 19))
                    r = 1 << 19;
                a = (r * r) >> 17;
                if (a > (1 << 20))
                    a = 1 << 20;
                return interp(1'b0, a >> 4);
            end
            default:     return interp(1'b1, x);
        endcase
    endfunction

    function automatic logic [31:0] blend_at(logic [15:0] pt);
        longint unsigned acc [4];
        longint unsigned total;
        longint unsigned d;
        longint unsigned w;
        longint unsigned v;
        logic [31:0] rgba;
        total = 0;
        rgba  = '0;
        for (int ch = 0; ch < 4; ch++)
            acc[ch] = 0;
        if (stop_count == 0)
            return BLACK;
        if (stop_count == 1)
            return stop_rgba[0];
        for (int i = 0; i < stop_count; i++)
        begin
            d = (pt > stop_pos[i]) ? pt - stop_pos[i] : stop_pos[i] - pt;
            if (wrap_on && d > 32768)
                d = 65536 - d;
            if (stop_spr[i] == 0)
            begin
                if (d == 0)
                    return stop_rgba[i];
                continue;
            end
            if (d > stop_spr[i])
                continue;
            w = falloff_weight(d, stop_spr[i]);
            for (int ch = 0; ch < 4; ch++)
                acc[ch] += w * stop_rgba[i][8*ch +: 8];
            total += w;
        end
        if (total == 0)
            return BLACK;
        for (int ch = 0; ch < 4; ch++)
        begin
            v = (2 * acc[ch] + total) / (2 * total);
            if (v > 255)
                v = 255;
            rgba[8*ch +: 8] = v[7:0];
        end
        return rgba;
    endfunction

    function automatic pixel_t apply_request(logic [1:0] op, logic [16:0] pos,
                                             logic [15:0] pt, logic [31:0] col,
                                             logic [16:0] spr);
        pixel_t px;
        logic [31:0] rgba;
        logic [16:0] p;
        logic [16:0] s;
        bit hit;
        px   = '0;
        rgba = '0;
        hit  = 0;
        px.status = ST_DONE;
        if (op == OP_SAMPLE)
            rgba = blend_at(pt);
        else if (op == OP_WRITE)
        begin
            p = (pos > ONE_Q16) ? ONE_Q16 : pos;
            s = (spr > ONE_Q16) ? ONE_Q16 : spr;
            for (int i = 0; i < stop_count; i++)
            begin
                if (!hit && stop_pos[i] == p)
                begin
                    stop_rgba[i] = col;
                    stop_spr[i]  = s;
                    hit = 1;
                end
            end
            if (hit)
                px.status = ST_OVER;
            else if (stop_count < ENTRIES)
            begin
                stop_pos[stop_count]  = p;
                stop_spr[stop_count]  = s;
                stop_rgba[stop_count] = col;
                stop_count++;
            end
            else
                px.status = ST_FULL;
        end
        else if (op == OP_CLEAR)
            stop_count = 0;
        px.red   = rgba[7:0];
        px.green = rgba[15:8];
        px.blue  = rgba[23:16];
        px.alpha = rgba[31:24];
        return px;
    endfunction

    // result checker
    always @(posedge clk)
    begin
        pixel_t want;
        pixel_t got;
        if (rst_n && done)
        begin
            got = '{red, green, blue, alpha, status};
            if (pending_pixels.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h", got);
            end
            else
            begin
                want = pending_pixels.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("want r%h g%h b%h a%h s%0d, got r%h g%h b%h a%h s%0d",
                                 want.red, want.green, want.blue, want.alpha, want.status,
                                 got.red, got.green, got.blue, got.alpha, got.status);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("spread_weighted_palette_sampler: mismatch");
            $finish;
        end
    end

    task automatic release_start();
        if (start)
        begin
            @(negedge clk);
            start = 1'b0;
        end
    endtask

    task automatic send_request(logic [1:0] op, logic [16:0] pos, logic [15:0] pt,
                                logic [31:0] col, logic [16:0] spr);
        @(negedge clk);
        operation    = op;
        position     = pos;
        sample_point = pt;
        colour       = col;
        spread       = spr;
        start        = 1'b1;
        do
            @(posedge clk);
        while (busy);
        pending_pixels.push_back(apply_request(op, pos, pt, col, spr));
        if ($urandom_range(99) < idle_pct)
        begin
            @(negedge clk);
            start = 1'b0;
            repeat ($urandom_range(1, 12))
                @(negedge clk);
        end
    endtask

    task automatic wait_drained();
        release_start();
        while (pending_pixels.size() != 0 || busy)
            @(posedge clk);
    endtask

    task automatic write_register(logic [1:0] idx, logic [16:0] value);
        wait_drained();
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_MODE:  falloff = value[1:0];
            CFG_WRAP:  wrap_on = value[0];
            CFG_SIGMA: sigma   = value;
            default:   ;
        endcase
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic test_special_cases();
        idle_pct = 0;
        send_request(OP_SAMPLE, 17'd0, 16'd0, 32'h0, 17'd0);
        send_request(OP_WRITE, 17'd0, 16'hFFFF, 32'hFFFF_FFFF, ONE_Q16);
        send_request(OP_SAMPLE, 17'h1FFFF, 16'hFFFF, 32'h0, 17'h1FFFF);
        send_request(OP_WRITE, ONE_Q16, 16'd0, 32'h0, 17'd0);
        send_request(OP_WRITE, HALF_Q16, 16'd0, 32'h1234_5678, 17'd0);
        // exact hit on a zero-width stop
        send_request(OP_SAMPLE, 17'd0, 16'h8000, 32'h0, 17'd0);
        send_request(OP_SAMPLE, 17'd0, 16'd40000, 32'h0, 17'd0);
        send_request(OP_WRITE, 17'd0, 16'd0, 32'hA5C3_3C5A, 17'd1);
        // nothing in reach
        send_request(OP_SAMPLE, 17'd0, 16'd60000, 32'h0, 17'd0);
        send_request(OP_CLEAR, 17'd0, 16'd0, 32'h0, 17'd0);
        for (int k = 0; k < ENTRIES; k++)
            send_request(OP_WRITE, 17'(k * 4096), 16'd0, $urandom, 17'd20000);
        send_request(OP_WRITE, ONE_Q16, 16'd0, 32'h0, 17'd100);
        send_request(OP_SAMPLE, 17'd0, 16'd2048, 32'h0, 17'd0);
    endtask

    task automatic run_random_items(int count);
        int r;
        logic [16:0] pos;
        logic [16:0] spr;
        logic [15:0] pt;
        for (int n = 0; n < count; n++)
        begin
            r = $urandom_range(99);
            if ($urandom_range(199) == 0)
                wait_drained();
            if (r < 4)
                send_request(OP_CLEAR, 17'($urandom), 16'($urandom), $urandom, 17'($urandom));
            else if (r < 42)
            begin
                pos = ($urandom_range(1)) ? 17'($urandom_range(16) * 4096)
                                          : 17'($urandom_range(65536));
                r = $urandom_range(99);
                spr = (r < 6) ? 17'd0 : (r < 12) ? ONE_Q16 : 17'($urandom_range(1, 40000));
                send_request(OP_WRITE, pos, 16'($urandom), $urandom, spr);
            end
            else
            begin
                pt = 16'($urandom);
                if (stop_count > 0 && $urandom_range(3) == 0)
                    pt = stop_pos[$urandom_range(stop_count - 1)][15:0];
                send_request(OP_SAMPLE, 17'($urandom), pt, $urandom, 17'($urandom));
            end
        end
    endtask

    task automatic test_falloff_settings();
        logic [16:0] sigma_pick;
        for (int ph = 0; ph < 16; ph++)
        begin
            case (ph % 4)
                0: sigma_pick = 17'd1;
                1: sigma_pick = ONE_Q16;
                2: sigma_pick = SIGMA_RESET;
                default: sigma_pick = 17'($urandom_range(1, 65536));
            endcase
            write_register(CFG_MODE, 17'(ph % 4));
            write_register(CFG_WRAP, 17'((ph / 4) % 2));
            write_register(CFG_SIGMA, sigma_pick);
            case (ph % 3)
                0: idle_pct = 0;
                1: idle_pct = 62;
                default: idle_pct = 16;
            endcase
            run_random_items(100);
        end
    endtask

    initial
    begin
        clk          = 1'b0;
        rst_n        = 1'b0;
        start        = 1'b0;
        operation    = OP_SAMPLE;
        position     = '0;
        sample_point = '0;
        colour       = '0;
        spread       = '0;
        cfg_valid    = 1'b0;
        cfg_index    = CFG_MODE;
        cfg_data     = '0;
        mismatches   = 0;
        cycles       = 0;
        idle_pct     = 0;
        stop_count   = 0;
        falloff      = MODE_LINEAR;
        wrap_on      = 1'b0;
        sigma        = SIGMA_RESET;
        fill_roms();
        repeat (9)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_special_cases();
        test_falloff_settings();

        wait_drained();
        repeat (100)
            @(posedge clk);
        if (mismatches == 0 && pending_pixels.size() == 0)
            $display("spread_weighted_palette_sampler: match");
        else
            $display("spread_weighted_palette_sampler: mismatch");
        $finish;
    end

endmodule
